// ----- src/meter_frame_encoder_core_macros.svh -----
// Assertion macros used by the checker file of the frame encoder.
`ifndef METER_FRAME_ENCODER_CORE_MACROS_SVH
`define METER_FRAME_ENCODER_CORE_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define MFE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/mfe_pkg.sv -----
package mfe_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int FRAME_BYTES  = HEADER_BYTES + 18;
    localparam int IDX_W        = $clog2(FRAME_BYTES);

    localparam int VERSION_W = 2;
    localparam int ID_W      = 27;
    localparam int PULSE_W   = 20;
    localparam int STATUS_W  = 10;
    localparam int WORD_W    = VERSION_W + ID_W + PULSE_W;
    localparam int GROUPS    = 7;

    // Input word packing, lowest bit first.
    localparam int VERSION_LSB = 0;
    localparam int ID_LSB      = VERSION_LSB + VERSION_W;
    localparam int PULSE_LSB   = ID_LSB + ID_W;
    localparam int STATUS_LSB  = PULSE_LSB + PULSE_W;
    localparam int IN_BITS     = STATUS_LSB + STATUS_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    localparam logic [4:0] LONG_MARK = 5'h1f;

    localparam logic [7:0] SYNC_0    = 8'he1;
    localparam logic [7:0] SYNC_1    = 8'h1a;
    localparam logic [7:0] SYNC_2    = 8'h03;
    localparam logic [7:0] PREAMBLE  = 8'h55;
    localparam logic [7:0] HDR_FINAL = 8'h5a;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [7:0]        t_byte;

    function automatic t_byte header_byte(input t_idx idx);
        t_byte b;
        if (idx == t_idx'(HEADER_BYTES - 1)) begin
            b = HDR_FINAL;
        end else if (idx == t_idx'(0)) begin
            b = SYNC_0;
        end else if (idx == t_idx'(1)) begin
            b = SYNC_1;
        end else if (idx == t_idx'(2)) begin
            b = SYNC_2;
        end else begin
            b = PREAMBLE;
        end
        return b;
    endfunction

    // Each bit becomes two: a one goes out as 01, a zero as 10.
    function automatic t_byte manchester_nibble(input logic [3:0] nib);
        t_byte b;
        for (int k = 0; k < 4; k++) begin
            b[2*k +: 2] = nib[k] ? 2'b01 : 2'b10;
        end
        return b;
    endfunction

    // Group g counts from the top of the word; even parity sits in bit 0.
    function automatic t_byte group_byte(input t_word word, input int g);
        logic [6:0] grp;
        grp = word[(WORD_W - 7 - 7*g) +: 7];
        return {grp, ^grp};
    endfunction

endpackage

// ----- src/meter_frame_encoder_core.sv -----
// Meter frame encoder.
// The slave stream takes one packet request per word: tuser carries the frame
// kind (0 short frame with pulse count, 1 long frame with status flags) and
// tdata carries version, meter id, pulse count and status flags. The master
// stream returns the radio frame one byte per word, header first, with tlast
// on the final byte; a frame is HEADER_BYTES + 18 words, 28 by default.
// The request is held in an input register; the byte for the current frame
// position is formed by short logic (group parity, column parity, Manchester
// coding) from the input register and lands in the output register once that
// register is free, so a request passes both registers before its first byte
// can be taken. Throughput is one byte per cycle while the receiver does not
// stall, and one request per frame, set by the byte counter that walks the
// frame. A new request is accepted in the same cycle that the last byte of the
// previous frame enters the output register, so frames follow without a gap.
// When the receiver stalls, the output register holds its byte and the byte
// counter waits; nothing is dropped. After reset both streams are idle and
// the block is ready for a request at once.
module meter_frame_encoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // version[1:0], meter_id[28:2], pulse_count[48:29], status_flags[58:49], zero fill
    input  logic [mfe_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // mode[0]
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // frame_byte[7:0]
    output logic [mfe_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);
    import mfe_pkg::*;

    localparam t_idx LAST_IDX = t_idx'(FRAME_BYTES - 1);

    logic  r_busy, n_busy;
    t_idx  r_idx, n_idx;
    t_word r_word, n_word;
    logic  r_m_valid, n_m_valid;
    t_byte r_m_data, n_m_data;
    logic  r_m_last, n_m_last;

    logic  s_accept, out_free, emit, last_emit;
    t_byte grp_bytes [GROUPS];
    t_byte col_byte, pay_byte, cur_byte;
    t_idx  pay_pos;
    logic [3:0] pay_sel;

    logic [VERSION_W-1:0] in_version;
    logic [ID_W-1:0]      in_id;
    logic [PULSE_W-1:0]   in_pulse;
    logic [STATUS_W-1:0]  in_status;

    assign in_version = i_s_axis_tdata[VERSION_LSB +: VERSION_W];
    assign in_id      = i_s_axis_tdata[ID_LSB +: ID_W];
    assign in_pulse   = i_s_axis_tdata[PULSE_LSB +: PULSE_W];
    assign in_status  = i_s_axis_tdata[STATUS_LSB +: STATUS_W];

    // The output register can take a byte when it is empty or being drained.
    assign out_free  = !r_m_valid || i_m_axis_tready;
    assign emit      = r_busy && out_free;
    assign last_emit = emit && (r_idx == LAST_IDX);

    assign o_s_axis_tready = !r_busy || last_emit;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Seven parity-protected groups and their column parity.
    always_comb begin
        col_byte = '0;
        for (int g = 0; g < GROUPS; g++) begin
            grp_bytes[g] = group_byte(r_word, g);
            col_byte     = col_byte ^ grp_bytes[g];
        end
    end

    // Past the header, every payload byte spans two frame positions.
    assign pay_pos = r_idx - t_idx'(HEADER_BYTES);
    assign pay_sel = pay_pos[4:1];

    always_comb begin
        if (pay_sel < 4'(GROUPS)) begin
            pay_byte = grp_bytes[pay_sel[2:0]];
        end else begin
            pay_byte = col_byte;
        end
        if (r_idx < t_idx'(HEADER_BYTES)) begin
            cur_byte = header_byte(r_idx);
        end else if (pay_pos[0]) begin
            cur_byte = manchester_nibble(pay_byte[3:0]);
        end else begin
            cur_byte = manchester_nibble(pay_byte[7:4]);
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_idx     = r_idx;
        n_word    = r_word;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;

        if (emit) begin
            n_m_valid = 1'b1;
            n_m_data  = cur_byte;
            n_m_last  = (r_idx == LAST_IDX);
            n_idx     = last_emit ? '0 : r_idx + t_idx'(1);
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        if (last_emit) begin
            n_busy = 1'b0;
        end

        if (s_accept) begin
            n_busy = 1'b1;
            n_idx  = '0;
            if (i_s_axis_tuser) begin
                n_word = {in_version, in_id, LONG_MARK, in_status, 5'b0};
            end else begin
                n_word = {in_version, in_id, in_pulse};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

endmodule

// ----- src/mfe_checker.sv -----
`include "meter_frame_encoder_core_macros.svh"

module mfe_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [mfe_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input logic                            i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [mfe_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);
    import mfe_pkg::*;

    logic s_acc;
    logic tdata_seen;

    assign s_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign tdata_seen = ^{i_s_axis_tdata, i_s_axis_tuser};

    // A stalled word keeps its value.
    `MFE_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output word changed")

    // An accepted request always has a word on the output once it has passed the input and output registers.
    `MFE_ASSERT_RST(a_out_follows, i_clk, i_rst_n, s_acc |=> ##1 o_m_axis_tvalid, "no output after request")

    // A new frame is running, so no second request right after one.
    `MFE_ASSERT_RST(a_one_request, i_clk, i_rst_n, s_acc |=> !o_s_axis_tready, "request taken mid-frame")

    // The final byte is Manchester coded.
    `MFE_ASSERT_RST(a_last_coded, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast |-> (o_m_axis_tdata[7] != o_m_axis_tdata[6]) && (o_m_axis_tdata[5] != o_m_axis_tdata[4]) && (o_m_axis_tdata[3] != o_m_axis_tdata[2]) && (o_m_axis_tdata[1] != o_m_axis_tdata[0]) && (tdata_seen || !tdata_seen), "last byte not Manchester coded")

endmodule

bind meter_frame_encoder_core mfe_checker u_mfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- dv/tb_meter_frame_encoder_core.sv -----
`timescale 1ns / 1ps

module tb_meter_frame_encoder_core;

    import mfe_pkg::*;

    // Run-length guard. The slowest correct run is about 200 requests of
    // 28 words each, with receiver stalls and sender gaps, well under the limit.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 180;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 20;

    // Frame header bytes.
    localparam t_byte LEAD_0    = 8'he1;
    localparam t_byte LEAD_1    = 8'h1a;
    localparam t_byte LEAD_2    = 8'h03;
    localparam t_byte FILL_BYTE = 8'h55;
    localparam t_byte LAST_HDR  = 8'h5a;
    localparam logic [4:0] LONG_TAG = 5'h1f;

    // Receiver stall styles.
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct packed {
        logic                 mode;
        logic [VERSION_W-1:0] version;
        logic [ID_W-1:0]      meter_id;
        logic [PULSE_W-1:0]   pulse_count;
        logic [STATUS_W-1:0]  status_flags;
    } t_meter_req;

    // A directed row either carries a typed payload byte (every coded payload
    // byte equals it) or leaves the payload to the frame predictor.
    typedef struct packed {
        t_meter_req req;
        logic       typed;
        t_byte      fill;
    } t_directed_row;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_frame_word;

    localparam int DIRECTED_ROWS = 14;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // Short frame, all zero: every payload bit is 0, so all coded bytes are aa.
        '{'{1'b0, 2'd0, 27'h0000000, 20'h00000, 10'h000}, 1'b1, 8'haa},
        // Short frame, all ones: groups are 7f with parity 1, coded as 55.
        '{'{1'b0, 2'd3, 27'h7ffffff, 20'hfffff, 10'h000}, 1'b1, 8'h55},
        // Long frame of zeros; the pulse count must be ignored.
        '{'{1'b1, 2'd0, 27'h0000000, 20'hfffff, 10'h000}, 1'b0, 8'h00},
        '{'{1'b1, 2'd3, 27'h7ffffff, 20'h00000, 10'h3ff}, 1'b0, 8'h00},
        // Short frame; the status flags must be ignored.
        '{'{1'b0, 2'd1, 27'h5555555, 20'haaaaa, 10'h3ff}, 1'b0, 8'h00},
        '{'{1'b0, 2'd2, 27'h2aaaaaa, 20'h55555, 10'h000}, 1'b0, 8'h00},
        // Tamper flag alone, then the lowest status flag alone.
        '{'{1'b1, 2'd1, 27'h0000001, 20'h00000, 10'h200}, 1'b0, 8'h00},
        '{'{1'b1, 2'd2, 27'h4000000, 20'h00000, 10'h001}, 1'b0, 8'h00},
        '{'{1'b0, 2'd0, 27'h4000000, 20'h00001, 10'h000}, 1'b0, 8'h00},
        '{'{1'b0, 2'd3, 27'h0000001, 20'h80000, 10'h000}, 1'b0, 8'h00},
        '{'{1'b1, 2'd3, 27'h1234567, 20'h00000, 10'h155}, 1'b0, 8'h00},
        '{'{1'b1, 2'd0, 27'h7654321, 20'hfffff, 10'h2aa}, 1'b0, 8'h00},
        // Only the lowest group is set.
        '{'{1'b0, 2'd0, 27'h0000000, 20'h0007f, 10'h000}, 1'b0, 8'h00},
        '{'{1'b1, 2'd1, 27'h7ffffff, 20'h00000, 10'h000}, 1'b0, 8'h00}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // version[1:0], meter_id[28:2], pulse_count[48:29], status_flags[58:49], zero fill
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    // mode[0]
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // frame_byte[7:0]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    t_frame_word expected_words[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          word_position = 0;
    int          rx_style = RX_ALWAYS;
    int          burst_left = 0;
    bit          quiet_stretch = 1'b0;
    t_frame_word oldest_word;

    meter_frame_encoder_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Manchester code of one nibble, most significant bit first:
    // a one is sent as 01 and a zero as 10.
    function automatic t_byte manchester_code(input logic [3:0] nib);
        t_byte code;
        code = '0;
        for (int k = 3; k >= 0; k--) begin
            code = {code[5:0], nib[k] ? 2'b01 : 2'b10};
        end
        return code;
    endfunction

    // Builds the whole coded frame for one request.
    function automatic void predict_frame(input t_meter_req r, output t_byte coded [FRAME_BYTES]);
        logic [WORD_W-1:0] payload;
        logic [6:0]        grp;
        t_byte             parity_bytes [9];
        t_byte             column;
        payload = r.mode ? {r.version, r.meter_id, LONG_TAG, r.status_flags, 5'b0}
                         : {r.version, r.meter_id, r.pulse_count};
        column = '0;
        for (int g = 0; g < GROUPS; g++) begin
            grp = payload[WORD_W - 1 - 7*g -: 7];
            parity_bytes[g] = {grp, ^grp};
            column ^= parity_bytes[g];
        end
        // The column parity byte goes out twice.
        parity_bytes[7] = column;
        parity_bytes[8] = column;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (i == HEADER_BYTES - 1) begin
                coded[i] = LAST_HDR;
            end else if (i == 0) begin
                coded[i] = LEAD_0;
            end else if (i == 1) begin
                coded[i] = LEAD_1;
            end else if (i == 2) begin
                coded[i] = LEAD_2;
            end else begin
                coded[i] = FILL_BYTE;
            end
        end
        for (int i = 0; i < 9; i++) begin
            coded[HEADER_BYTES + 2*i]     = manchester_code(parity_bytes[i][7:4]);
            coded[HEADER_BYTES + 2*i + 1] = manchester_code(parity_bytes[i][3:0]);
        end
    endfunction

    // Picks a field value, leaning toward the extremes now and then.
    function automatic logic [31:0] pick_field(input int width);
        logic [31:0] mask;
        int          sel;
        mask = (32'h1 << width) - 32'h1;
        sel  = $urandom_range(0, 7);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return mask;
        end
        return $urandom() & mask;
    endfunction

    // Offers one request, waits for it to be taken, then queues its frame.
    // Typed rows replace every coded payload byte with the given value.
    task automatic send_request(input t_meter_req r, input logic typed, input t_byte fill);
        logic [IN_DATA_W-1:0] packed_data;
        t_byte                coded [FRAME_BYTES];
        int                   gap;
        packed_data = '0;
        packed_data[VERSION_LSB +: VERSION_W] = r.version;
        packed_data[ID_LSB +: ID_W]           = r.meter_id;
        packed_data[PULSE_LSB +: PULSE_W]     = r.pulse_count;
        packed_data[STATUS_LSB +: STATUS_W]   = r.status_flags;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= packed_data;
        i_s_axis_tuser  <= r.mode;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        predict_frame(r, coded);
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (typed && i >= HEADER_BYTES) begin
                coded[i] = fill;
            end
            expected_words.push_back('{data: coded[i], last: (i == FRAME_BYTES - 1)});
        end
        // Sender bursts: after a burst runs out, drop valid for a random gap
        // long enough to land anywhere within a frame.
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0 && !quiet_stretch) begin
            burst_left = $urandom_range(1, 5);
            gap = $urandom_range(1, 40);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: its own stall pattern, switched by the stimulus.
    always @(posedge i_clk) begin
        case (rx_style)
            RX_ALWAYS: begin
                i_m_axis_tready <= 1'b1;
            end
            RX_RANDOM: begin
                i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                // Long stalls on a fixed rhythm, with a little noise on top.
                i_m_axis_tready <= ((cycle_count % 23) > 9) && ($urandom_range(0, 9) != 0);
            end
        endcase
    end

    // Output checker: each accepted word against the oldest expected word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_words.size() == 0) begin
                error_count++;
                if (error_count <= PRINT_LIMIT) begin
                    $display("%0t: unexpected word: expected none, actual data %02h last %0b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                end
            end else begin
                oldest_word = expected_words.pop_front();
                if (o_m_axis_tdata !== oldest_word.data) begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT) begin
                        $display("%0t: frame byte %0d data: expected %02h, actual %02h",
                                 $time, word_position, oldest_word.data, o_m_axis_tdata);
                    end
                end
                if (o_m_axis_tlast !== oldest_word.last) begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT) begin
                        $display("%0t: frame byte %0d last: expected %0b, actual %0b",
                                 $time, word_position, oldest_word.last, o_m_axis_tlast);
                    end
                end
                word_position = oldest_word.last ? 0 : word_position + 1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        t_meter_req req;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, receiver always ready at first, then random stalls.
        foreach (directed_rows[i]) begin
            rx_style = (i < DIRECTED_ROWS / 2) ? RX_ALWAYS : RX_RANDOM;
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].fill);
        end

        // Random part. One stretch runs with no idling on either side, and
        // once the sender holds off until every queued word has come out.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_stretch = (n >= 40 && n < 70);
            if (quiet_stretch) begin
                rx_style = RX_ALWAYS;
            end else if (n % 30 == 0) begin
                rx_style = $urandom_range(RX_ALWAYS, RX_PATTERN);
            end
            if (n == 100) begin
                i_s_axis_tvalid <= 1'b0;
                while (expected_words.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            req.mode         = 1'($urandom_range(0, 1));
            req.version      = VERSION_W'(pick_field(VERSION_W));
            req.meter_id     = ID_W'(pick_field(ID_W));
            req.pulse_count  = PULSE_W'(pick_field(PULSE_W));
            req.status_flags = STATUS_W'(pick_field(STATUS_W));
            send_request(req, 1'b0, 8'h00);
        end

        i_s_axis_tvalid <= 1'b0;
        rx_style = RX_RANDOM;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/mfe_pkg.sv
src/meter_frame_encoder_core.sv
src/mfe_checker.sv
dv/tb_meter_frame_encoder_core.sv
